/* rtl/core/bfhp_pkg.sv */
// Shared types and constants for the beacon frame header parser.
// No dependencies; imported by bfhp_decode, beacon_frame_header_parser and the testbench.
`timescale 1ns / 1ps

package bfhp_pkg;

  // Frame layout constants
  localparam int unsigned LEGACY_MIN_LEN = 8;   // magic, version, source id, sequence
  localparam int unsigned HDR_LEN        = 12;  // current-version header
  localparam int unsigned POSITION_LEN   = 10;  // lat, lon, satellites, one spare
  localparam int unsigned TAIL_LEN       = 18;  // legacy frame with flags byte
  localparam int unsigned LEGACY_FLAGS   = 17;  // legacy flags byte index
  localparam int unsigned LEGACY_POS     = 8;   // legacy position start
  // Highest frame byte that any field reads; bytes 1..BUF_LAST are held.
  localparam int unsigned BUF_LAST       = HDR_LEN + 8;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned TDATA_W    = 176;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MAGIC_BYTE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEGACY_VERSION = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CURRENT_VER    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_POSITION_MASK  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIC_MASK       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ENCRYPTED_MASK = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_OPEN_GROUP     = 3'd6;

  typedef struct packed {
    logic [7:0] magic_byte;
    logic [7:0] legacy_version;
    logic [7:0] current_version;
    logic [7:0] position_flag_mask;
    logic [7:0] mic_flag_mask;
    logic [7:0] encrypted_flag_mask;
    logic [7:0] open_group_hash;
  } bfhp_cfg_t;

  localparam bfhp_cfg_t CFG_RESET = '{
    magic_byte:          8'h00,
    legacy_version:      8'h01,
    current_version:     8'h02,
    position_flag_mask:  8'h01,
    mic_flag_mask:       8'h02,
    encrypted_flag_mask: 8'h04,
    open_group_hash:     8'h00
  };

  // Held frame bytes, index 1 upward
  typedef logic [BUF_LAST:1][7:0] hdr_buf_t;

  // Result fields, last member in the lowest bits
  typedef struct packed {
    logic [4:0]         mic_bytes;
    logic [7:0]         payload_bytes;
    logic [7:0]         satellites;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic               position_valid;
    logic [31:0]        packet_number;
    logic [31:0]        source_id;
    logic [7:0]         flag_bits;
    logic [7:0]         group_hash;
    logic [7:0]         version;
  } bfhp_fields_t;

  typedef struct packed {
    logic         status;   // 1 = error
    bfhp_fields_t fields;
  } bfhp_result_t;

  // Little-endian 32-bit word starting at byte idx
  function automatic logic [31:0] buf_u32(hdr_buf_t b, int unsigned idx);
    return {b[idx+3], b[idx+2], b[idx+1], b[idx]};
  endfunction

endpackage

/* rtl/core/bfhp_decode.sv */
// Frame decode: turns the held header bytes and frame length into one result.
// Depends on bfhp_pkg.
`timescale 1ns / 1ps

module bfhp_decode import bfhp_pkg::*; #(
  parameter int MIC_BYTES = 4,
  parameter int LEN_W     = 9
) (
  input  bfhp_cfg_t    cfg,
  input  hdr_buf_t     frame_buf,
  input  logic [LEN_W-1:0] frame_len,
  input  logic         len_ok,      // frame not longer than the limit
  input  logic         magic_ok,
  output bfhp_result_t result
);

  localparam int CMP_W = LEN_W + 2;

  logic [CMP_W-1:0] len_x;
  logic [7:0]       ver;
  logic [7:0]       flags_cur;
  logic [7:0]       flags_leg;
  logic [CMP_W-1:0] mic_len;
  logic [CMP_W-1:0] pay_len;
  logic             cur_pos;

  always_comb begin
    len_x     = CMP_W'(frame_len);
    ver       = frame_buf[1];
    flags_cur = frame_buf[3];
    flags_leg = frame_buf[LEGACY_FLAGS];
    mic_len   = ((flags_cur & cfg.mic_flag_mask) != 8'd0) ? CMP_W'(MIC_BYTES) : '0;
    pay_len   = len_x - CMP_W'(HDR_LEN) - mic_len;
    cur_pos   = ((flags_cur & cfg.position_flag_mask) != 8'd0) &&
                ((flags_cur & cfg.encrypted_flag_mask) == 8'd0);

    // default: error record, version shown once byte 1 exists with good magic
    result        = '0;
    result.status = 1'b1;
    if (len_x >= CMP_W'(2) && magic_ok) begin
      result.fields.version = ver;
    end

    if (len_x >= CMP_W'(2) && magic_ok && len_ok) begin
      if (ver <= cfg.legacy_version) begin
        if (len_x >= CMP_W'(LEGACY_MIN_LEN)) begin
          result.status                = 1'b0;
          result.fields.group_hash     = cfg.open_group_hash;
          result.fields.source_id      = buf_u32(frame_buf, 2);
          result.fields.packet_number  = {16'd0, frame_buf[7], frame_buf[6]};
          if (ver >= cfg.legacy_version && len_x >= CMP_W'(TAIL_LEN)) begin
            result.fields.flag_bits = flags_leg;
            if ((flags_leg & cfg.position_flag_mask) != 8'd0) begin
              result.fields.position_valid = 1'b1;
              result.fields.latitude       = buf_u32(frame_buf, LEGACY_POS);
              result.fields.longitude      = buf_u32(frame_buf, LEGACY_POS + 4);
              result.fields.satellites     = frame_buf[LEGACY_POS + 8];
            end
          end
        end
      end else if (ver == cfg.current_version &&
                   len_x >= CMP_W'(HDR_LEN) + mic_len) begin
        // clear position flagged but payload too short: error record stays
        if (!cur_pos || pay_len >= CMP_W'(POSITION_LEN)) begin
          result.status               = 1'b0;
          result.fields.group_hash    = frame_buf[2];
          result.fields.flag_bits     = flags_cur;
          result.fields.source_id     = buf_u32(frame_buf, 4);
          result.fields.packet_number = buf_u32(frame_buf, 8);
          result.fields.payload_bytes = pay_len[7:0];
          result.fields.mic_bytes     = mic_len[4:0];
          if (cur_pos) begin
            result.fields.position_valid = 1'b1;
            result.fields.latitude       = buf_u32(frame_buf, HDR_LEN);
            result.fields.longitude      = buf_u32(frame_buf, HDR_LEN + 4);
            result.fields.satellites     = frame_buf[HDR_LEN + 8];
          end
        end
      end
    end
  end

endmodule

/* rtl/core/beacon_frame_header_parser.sv */
// Top level of the beacon frame header parser: input beat register, frame
// byte counter, header byte latches, result register. Depends on bfhp_pkg, bfhp_decode.
`timescale 1ns / 1ps

// Usage
//   in_*  : one frame byte per beat in in_tdata, in_tlast on the final byte.
//   out_* : one result beat per frame; out_tuser is the status (1 = error),
//           out_tdata the decoded header fields.
//   cfg_* : plain register writes, taken whenever cfg_we is high; write only
//           while no frame is in flight.
// Timing
//   Throughput is one byte per cycle, back to back, while no final byte is
//   held for a full result register. A byte waits in the input register and
//   is then folded into the byte counter and latches; for the final byte the
//   decode runs in that same cycle and loads the result register at the next
//   edge, which raises out_tvalid.
// Reset (rst_n low, synchronous) empties both registers, zeroes the byte
// counter and restores the register defaults.
// Stall: while a result waits on out_tready, non-final bytes keep flowing;
// only a final byte waits in the input register, and in_tready drops behind it.

module beacon_frame_header_parser import bfhp_pkg::*; #(
  parameter int MIC_BYTES = 4,
  parameter int MAX_FRAME = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream; tdata: [7:0] frame_byte; tlast: last_byte
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tlast,
  // result stream; tuser: [0] status
  // tdata: [7:0] version, [15:8] group_hash, [23:16] flag_bits,
  //        [55:24] source_id, [87:56] packet_number, [88] position_valid,
  //        [120:89] latitude, [152:121] longitude, [160:153] satellites,
  //        [168:161] payload_bytes, [173:169] mic_bytes, [175:174] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,
  output logic                  out_tuser,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // counter saturates at MAX_FRAME + 1
  localparam int LEN_W = $clog2(MAX_FRAME + 2);

  bfhp_cfg_t        cfg_r, cfg_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;

  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             magic_ok_r, magic_ok_nxt;
  hdr_buf_t         byte_r;

  bfhp_result_t     out_r;
  logic             out_valid_r, out_valid_nxt;

  logic             in_fire;
  logic             s1_fire;
  logic             out_free;
  logic             frame_end;
  logic             pos_room;
  logic             len_ok;
  logic [LEN_W-1:0] frame_len;
  logic             magic_eff;
  hdr_buf_t         frame_buf;
  bfhp_result_t     dec_result;

  // ---------------------------------------------------------------- config
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAGIC_BYTE:     cfg_nxt.magic_byte          = cfg_wdata;
        CFG_LEGACY_VERSION: cfg_nxt.legacy_version      = cfg_wdata;
        CFG_CURRENT_VER:    cfg_nxt.current_version     = cfg_wdata;
        CFG_POSITION_MASK:  cfg_nxt.position_flag_mask  = cfg_wdata;
        CFG_MIC_MASK:       cfg_nxt.mic_flag_mask       = cfg_wdata;
        CFG_ENCRYPTED_MASK: cfg_nxt.encrypted_flag_mask = cfg_wdata;
        CFG_OPEN_GROUP:     cfg_nxt.open_group_hash     = cfg_wdata;
        default:            cfg_nxt = cfg_r;   // unmapped index: drop the write
      endcase
    end
  end

  // ------------------------------------------------------------ handshakes
  assign out_free  = !out_valid_r || out_tready;
  // a final byte needs the result register free; other bytes never wait
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;
  assign frame_end = s1_fire && s1_last_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // ------------------------------------------------------- frame tracking
  assign pos_room  = (pos_r <= LEN_W'(MAX_FRAME));
  assign frame_len = pos_r + LEN_W'(pos_room);
  // frame including the byte in the input register still fits the limit
  assign len_ok    = (pos_r < LEN_W'(MAX_FRAME));
  assign magic_eff = (pos_r == '0) ? (s1_byte_r == cfg_r.magic_byte) : magic_ok_r;

  always_comb begin
    pos_nxt      = pos_r;
    magic_ok_nxt = magic_ok_r;
    if (s1_fire) begin
      if (s1_last_r) begin
        pos_nxt      = '0;
        magic_ok_nxt = 1'b0;
      end else begin
        magic_ok_nxt = magic_eff;
        if (pos_room) begin
          pos_nxt = pos_r + LEN_W'(1);
        end
      end
    end
  end

  // view of the frame with the byte now in the input register merged in
  always_comb begin
    for (int i = 1; i <= BUF_LAST; i++) begin
      frame_buf[i] = (pos_r == LEN_W'(i)) ? s1_byte_r : byte_r[i];
    end
  end

  bfhp_decode #(
    .MIC_BYTES (MIC_BYTES),
    .LEN_W     (LEN_W)
  ) u_decode (
    .cfg       (cfg_r),
    .frame_buf (frame_buf),
    .frame_len (frame_len),
    .len_ok    (len_ok),
    .magic_ok  (magic_eff),
    .result    (dec_result)
  );

  // ---------------------------------------------------------- result side
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (frame_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {{(TDATA_W - $bits(bfhp_fields_t)){1'b0}}, out_r.fields};

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      s1_valid_r  <= 1'b0;
      pos_r       <= '0;
      magic_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      pos_r       <= pos_nxt;
      magic_ok_r  <= magic_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: input beat, header byte latches, result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    for (int i = 1; i <= BUF_LAST; i++) begin
      if (s1_fire && pos_r == LEN_W'(i)) begin
        byte_r[i] <= s1_byte_r;
      end
    end
    if (frame_end) begin
      out_r <= dec_result;
    end
  end

  // ------------------------------------------------------------ assertions
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LEN_W'(MAX_FRAME + 1))
    else $error("byte counter past saturation");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> (pos_r == '0) && !magic_ok_r)
    else $error("frame state not cleared after final byte");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(frame_end))
    else $error("result shown without a final byte");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status) |->
      (out_r.fields.source_id == '0) && !out_r.fields.position_valid &&
      (out_r.fields.payload_bytes == '0))
    else $error("error result carries decoded fields");

  a_no_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.fields.position_valid) |->
      (out_r.fields.latitude == '0) && (out_r.fields.satellites == '0))
    else $error("position fields set without valid position");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for beacon_frame_header_parser: streams beacon frames
// byte by byte and compares each decoded header against a local predictor.
// Depends on bfhp_pkg and the beacon_frame_header_parser RTL.
`timescale 1ns / 1ps

module testbench;
  import bfhp_pkg::*;

  localparam int MIC_LEN        = 4;
  localparam int FRAME_LIMIT    = 256;
  localparam int HALF_PERIOD    = 4;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int PHASES         = 6;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;  // long receiver hold-off
  localparam int HOLD_AT_RESULT = 20;
  localparam int HOLD_BACKLOG   = 40;   // least number of beats still queued when the hold-off starts

  // Register index past the end of the map; the block must ignore it
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_INDEX = 3'd7;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZERO} fill_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Stimulus and scoreboard state
  beat_t        frame_beats[$];       // beats waiting for the driver
  bfhp_result_t pending_headers[$];   // predicted results, oldest first
  bfhp_cfg_t    regs = CFG_RESET;     // shadow of the register file

  // Predictor copy of the frame being received
  int          frame_len = 0;
  logic [7:0]  frame_bytes [32];
  logic        magic_seen = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_queued = 0;
  int frames_queued = 0;
  int headers_checked = 0;
  int error_headers = 0;
  int position_headers = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  beacon_frame_header_parser #(
    .MIC_BYTES(MIC_LEN),
    .MAX_FRAME(FRAME_LIMIT)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] frame_byte
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // version, group_hash, flag_bits, source_id, packet_number,
                              // position_valid, latitude, longitude, satellites,
                              // payload_bytes, mic_bytes, then two zero pad bits
    .out_tuser  (out_tuser),  // [0] status, 1 = error
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Header predictor
  // ---------------------------------------------------------------------------

  // Little-endian word out of the held frame bytes
  function automatic logic [31:0] frame_word(input int idx);
    return {frame_bytes[idx+3], frame_bytes[idx+2], frame_bytes[idx+1], frame_bytes[idx]};
  endfunction

  // Decode the completed frame into the header the block should report
  function automatic bfhp_result_t decode_frame();
    bfhp_result_t r;
    logic [7:0]   ver;
    logic [7:0]   flags;
    int           plen;
    int           mic;
    int           pay;
    bit           clear_pos;
    r = '0;
    r.status = 1'b1;
    ver = frame_bytes[1];
    // Error results still carry the version once magic and length allow it
    if (frame_len >= 2 && magic_seen) r.fields.version = ver;
    if (frame_len < 2 || !magic_seen || frame_len > FRAME_LIMIT) return r;

    // Legacy test comes first, so it wins when current is not above legacy
    if (ver <= regs.legacy_version) begin
      if (frame_len >= LEGACY_MIN_LEN) begin
        r.status = 1'b0;
        r.fields.group_hash = regs.open_group_hash;
        r.fields.source_id = frame_word(2);
        r.fields.packet_number = {16'd0, frame_bytes[7], frame_bytes[6]};
        // Flags and position tail only exist at exactly the legacy version
        if (ver == regs.legacy_version && frame_len >= TAIL_LEN) begin
          flags = frame_bytes[LEGACY_FLAGS];
          r.fields.flag_bits = flags;
          if ((flags & regs.position_flag_mask) != 0) begin
            r.fields.position_valid = 1'b1;
            r.fields.latitude = frame_word(LEGACY_POS);
            r.fields.longitude = frame_word(LEGACY_POS + 4);
            r.fields.satellites = frame_bytes[LEGACY_POS + 8];
          end
        end
      end
    end else if (ver == regs.current_version && frame_len >= HDR_LEN) begin
      flags = frame_bytes[3];
      plen = frame_len - HDR_LEN;
      mic = ((flags & regs.mic_flag_mask) != 0) ? MIC_LEN : 0;
      if (plen >= mic) begin
        pay = plen - mic;
        clear_pos = ((flags & regs.position_flag_mask) != 0) &&
                    ((flags & regs.encrypted_flag_mask) == 0);
        if (clear_pos) begin
          // A clear position needs the whole position block in the payload
          if (pay < POSITION_LEN) return r;
          r.fields.position_valid = 1'b1;
          r.fields.latitude = frame_word(HDR_LEN);
          r.fields.longitude = frame_word(HDR_LEN + 4);
          r.fields.satellites = frame_bytes[HDR_LEN + 8];
        end
        r.status = 1'b0;
        r.fields.group_hash = frame_bytes[2];
        r.fields.flag_bits = flags;
        r.fields.source_id = frame_word(4);
        r.fields.packet_number = frame_word(8);
        r.fields.payload_bytes = pay[7:0];
        r.fields.mic_bytes = mic[4:0];
      end
    end
    return r;
  endfunction

  // Fold one accepted beat into the frame; the final beat yields a header
  task automatic predict_byte(input logic [7:0] b, input logic last);
    if (frame_len == 0) magic_seen = (b == regs.magic_byte);
    if (frame_len < 32) frame_bytes[frame_len] = b;
    if (frame_len <= FRAME_LIMIT) frame_len++;
    if (last) begin
      pending_headers.push_back(decode_frame());
      frame_len = 0;
      frame_bytes = '{default: 8'h00};
      magic_seen = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued beats, hold each one until it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_beats
    beat_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
      // Advance only when the slot is empty or its beat was just taken
      if (!in_tvalid || in_tready) begin
        if (frame_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = frame_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.data;
          in_tlast <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every result beat with the oldest predicted header
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_header();
    bfhp_result_t want;
    bfhp_fields_t got;
    got = out_tdata[$bits(bfhp_fields_t)-1:0];
    if (pending_headers.size() == 0) begin
      $error("result beat with no frame pending: tuser=%0b tdata=0x%0h", out_tuser, out_tdata);
      mismatches++;
    end else begin
      want = pending_headers.pop_front();
      headers_checked++;
      if (want.status) error_headers++;
      if (want.fields.position_valid) position_headers++;
      compare_field("status", 32'(want.status), 32'(out_tuser));
      compare_field("version", 32'(want.fields.version), 32'(got.version));
      compare_field("group_hash", 32'(want.fields.group_hash), 32'(got.group_hash));
      compare_field("flag_bits", 32'(want.fields.flag_bits), 32'(got.flag_bits));
      compare_field("source_id", want.fields.source_id, got.source_id);
      compare_field("packet_number", want.fields.packet_number, got.packet_number);
      compare_field("position_valid", 32'(want.fields.position_valid),
                    32'(got.position_valid));
      compare_field("latitude", want.fields.latitude, got.latitude);
      compare_field("longitude", want.fields.longitude, got.longitude);
      compare_field("satellites", 32'(want.fields.satellites), 32'(got.satellites));
      compare_field("payload_bytes", 32'(want.fields.payload_bytes),
                    32'(got.payload_bytes));
      compare_field("mic_bytes", 32'(want.fields.mic_bytes), 32'(got.mic_bytes));
      compare_field("tdata pad", 32'd0, 32'(out_tdata[TDATA_W-1:$bits(bfhp_fields_t)]));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_header();
      // One long hold-off while the sender keeps offering: the block fills
      // up behind a final byte and must drop in_tready
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (headers_checked >= HOLD_AT_RESULT && !hold_done &&
                   frame_beats.size() >= HOLD_BACKLOG) begin
        out_tready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue one frame: the first four bytes given, the rest filled as asked
  task automatic add_frame(input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3,
                           input int len, input fill_t fill);
    beat_t      bt;
    logic [7:0] hd [4];
    hd = '{b0, b1, b2, b3};
    for (int i = 0; i < len; i++) begin
      if (i < 4) bt.data = hd[i];
      else if (fill == FILL_ONES) bt.data = 8'hFF;
      else if (fill == FILL_ZERO) bt.data = 8'h00;
      else bt.data = 8'($urandom_range(255, 0));
      bt.last = (i == len - 1);
      frame_beats.push_back(bt);
    end
    beats_queued += len;
    frames_queued++;
  endtask

  task automatic add_random_frame();
    int         pick;
    int         len;
    logic [7:0] ver;
    logic [7:0] flags;
    pick = $urandom_range(99, 0);
    if (pick < 40) begin
      // Legacy frame, mostly at the version that carries the tail
      ver = ($urandom_range(2, 0) != 0) ? regs.legacy_version :
            8'($urandom_range(regs.legacy_version, 0));
      len = ($urandom_range(2, 0) != 0) ? $urandom_range(32, 18) : $urandom_range(17, 8);
      add_frame(regs.magic_byte, ver, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                len, FILL_RANDOM);
    end else if (pick < 80) begin
      // Current-version frame; bias the flags toward a clear position
      flags = 8'($urandom_range(255, 0));
      if ($urandom_range(1, 0)) flags |= regs.position_flag_mask;
      if ($urandom_range(1, 0)) flags &= ~regs.encrypted_flag_mask;
      len = HDR_LEN + $urandom_range(24, 0);
      add_frame(regs.magic_byte, regs.current_version, 8'($urandom_range(255, 0)), flags,
                len, FILL_RANDOM);
    end else if (pick < 89) begin
      // Noise: anything at all, usually a bad magic
      add_frame(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                $urandom_range(20, 1), FILL_RANDOM);
    end else if (pick < 99) begin
      // Truncated frame with a good magic
      case ($urandom_range(2, 0))
        0:       ver = regs.legacy_version;
        1:       ver = regs.current_version;
        default: ver = 8'($urandom_range(255, 0));
      endcase
      add_frame(regs.magic_byte, ver, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                $urandom_range(11, 1), FILL_RANDOM);
    end else begin
      // Frame around the length limit
      add_frame(regs.magic_byte, regs.current_version, 8'($urandom_range(255, 0)), 8'h00,
                $urandom_range(FRAME_LIMIT + 14, FRAME_LIMIT - 6), FILL_RANDOM);
    end
  endtask

  // Edge cases at the reset register values
  task automatic queue_directed();
    logic [7:0] mg;
    logic [7:0] lv;
    logic [7:0] cv;
    logic [7:0] pos;
    logic [7:0] mic;
    logic [7:0] enc;
    mg = regs.magic_byte;
    lv = regs.legacy_version;
    cv = regs.current_version;
    pos = regs.position_flag_mask;
    mic = regs.mic_flag_mask;
    enc = regs.encrypted_flag_mask;
    add_frame(mg, 8'h00, 8'h00, 8'h00, 1, FILL_ZERO);          // single byte, good magic
    add_frame(~mg, 8'h00, 8'h00, 8'h00, 1, FILL_ZERO);         // single byte, bad magic
    add_frame(~mg, lv, 8'h12, 8'h34, 8, FILL_RANDOM);          // bad magic, full legacy
    add_frame(mg, lv, 8'h12, 8'h34, 7, FILL_RANDOM);           // legacy one byte short
    add_frame(mg, 8'h00, 8'hFF, 8'hFF, 8, FILL_ONES);          // oldest version, shortest
    add_frame(mg, lv, 8'hFF, 8'hFF, TAIL_LEN, FILL_ONES);      // tail with position flagged
    add_frame(mg, lv, 8'h00, 8'h00, TAIL_LEN, FILL_ZERO);      // tail, flags clear
    add_frame(mg, 8'h00, 8'hA5, 8'h5A, 20, FILL_ONES);         // below legacy: tail ignored
    add_frame(mg, 8'hFF, 8'hFF, 8'hFF, HDR_LEN, FILL_ONES);    // unknown version
    add_frame(mg, cv, 8'h00, 8'h00, HDR_LEN - 1, FILL_RANDOM); // header one byte short
    add_frame(mg, cv, 8'h00, mic, HDR_LEN, FILL_ZERO);         // no room for the MIC
    add_frame(mg, cv, 8'hFF, mic, HDR_LEN + MIC_LEN, FILL_ONES);  // MIC, empty payload
    add_frame(mg, cv, 8'h00, pos, HDR_LEN + POSITION_LEN - 1, FILL_RANDOM); // short position
    add_frame(mg, cv, 8'hFF, pos, HDR_LEN + POSITION_LEN, FILL_ONES);       // exact position
    add_frame(mg, cv, 8'h00, pos | mic, HDR_LEN + POSITION_LEN + MIC_LEN, FILL_ZERO);
    add_frame(mg, cv, 8'h00, pos | enc, HDR_LEN, FILL_RANDOM); // encrypted: position skipped
    add_frame(mg, cv, 8'h3C, 8'h00, FRAME_LIMIT, FILL_RANDOM);     // longest legal frame
    add_frame(mg, lv, 8'hC3, 8'h00, FRAME_LIMIT + 1, FILL_RANDOM); // one byte too long
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MAGIC_BYTE:     regs.magic_byte = val;
      CFG_LEGACY_VERSION: regs.legacy_version = val;
      CFG_CURRENT_VER:    regs.current_version = val;
      CFG_POSITION_MASK:  regs.position_flag_mask = val;
      CFG_MIC_MASK:       regs.mic_flag_mask = val;
      CFG_ENCRYPTED_MASK: regs.encrypted_flag_mask = val;
      CFG_OPEN_GROUP:     regs.open_group_hash = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input bfhp_cfg_t s);
    write_reg(CFG_MAGIC_BYTE, s.magic_byte);
    write_reg(CFG_LEGACY_VERSION, s.legacy_version);
    write_reg(CFG_CURRENT_VER, s.current_version);
    write_reg(CFG_POSITION_MASK, s.position_flag_mask);
    write_reg(CFG_MIC_MASK, s.mic_flag_mask);
    write_reg(CFG_ENCRYPTED_MASK, s.encrypted_flag_mask);
    write_reg(CFG_OPEN_GROUP, s.open_group_hash);
    write_reg(CFG_SPARE_INDEX, 8'($urandom_range(255, 0)));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Register settings per phase: defaults first, then the extremes,
  // overlapping masks and a current version that the legacy test shadows
  function automatic bfhp_cfg_t phase_settings(input int p);
    bfhp_cfg_t s;
    case (p)
      0:       s = CFG_RESET;
      1:       s = '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h40, 8'h20, 8'hFF};
      2:       s = '{8'h5A, 8'hFF, 8'h00, 8'h01, 8'h02, 8'h04, 8'h3C};
      3:       s = '{8'hA5, 8'h04, 8'h07, 8'h11, 8'h22, 8'h11, 8'h96};
      4:       s = '{8'h7E, 8'h05, 8'h03, 8'hFF, 8'hFF, 8'h00, 8'h00};
      default: s = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h81};
    endcase
    return s;
  endfunction

  // Hold until every queued beat is taken and every header has come back,
  // then let the block settle
  task automatic wait_drained();
    while (frame_beats.size() != 0 || in_tvalid || pending_headers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int start;
    frame_bytes = '{default: 8'h00};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      // Sender mostly busy first, then receiver mostly busy, then no gaps
      if (p < 2) begin
        send_idle_pct = 23;
        recv_idle_pct = 80;
      end else if (p < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_settings(phase_settings(p));
      if (p == 0) queue_directed();
      start = beats_queued;
      while (beats_queued - start < ITEMS_PER_PHASE) add_random_frame();
      wait_drained();
    end

    $display("Run covered %0d frames in %0d beats over %0d register settings.",
             frames_queued, beats_queued, PHASES);
    $display("Headers checked: %0d, of them %0d errors and %0d with a position.",
             headers_checked, error_headers, position_headers);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
